/* rtl/bta_pkg.sv */
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types and codes for the block table heap allocator: the controller
// states, the layout of one table entry, request functions and status codes.
// ----------------------------------------------------------------------------
package bta_pkg;

	// Field widths of the request and result words and of the block count register
	localparam int SIZE_W   = 23;
	localparam int ADDR_W   = 32;
	localparam int STATUS_W = 2;
	localparam int BIU_W    = 11;

	// One table entry: taken, first of a run, run continues in the next entry
	localparam int ENT_W     = 3;
	localparam int ENT_TAKEN = 0;
	localparam int ENT_FIRST = 1;
	localparam int ENT_NEXT  = 2;

	typedef logic [ENT_W-1:0] entry_t;

	localparam entry_t ENTRY_FREE = '0;

	// Request functions
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// Result status codes
	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK  = 2'd0;
	localparam status_t ST_OOM = 2'd1;
	localparam status_t ST_BAD = 2'd2;

	// Configuration register indexes
	localparam logic CFG_BASE   = 1'b0;
	localparam logic CFG_BLOCKS = 1'b1;

	// Controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_MARK,
		S_FWALK,
		S_FCHAIN,
		S_RESP
	} state_t;

endpackage

/* rtl/bta_ram.sv */
// ----------------------------------------------------------------------------
// bta_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module bta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/block_table_heap_allocator.sv */
// Allocate: a table scan over the entries in use, then the marking of each
// block of the found run, then the loading of the result word.
// Free: a walk over the blocks below the freed address, then the clearing of
// the entries of its chain; one request at a time.
// After reset every table entry is swept to free; no request is taken during
// the sweep (configuration writes are).
// ----------------------------------------------------------------------------
// block_table_heap_allocator
// First-fit heap allocator over a table of fixed-size blocks held in one RAM.
// Allocate scans for a free run and marks it; free clears a chain of entries.
// ----------------------------------------------------------------------------
module block_table_heap_allocator #(
	parameter int NUM_BLOCKS = 1024,
	parameter int BLOCK_SIZE = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,

	// Configuration write port
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [31:0]              cfg_wdata,

	// Request channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     func,
	input  logic [bta_pkg::SIZE_W-1:0] size_bytes,
	input  logic [bta_pkg::ADDR_W-1:0] address,

	// Result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [bta_pkg::ADDR_W-1:0] result_address,
	output logic [bta_pkg::STATUS_W-1:0] status
);

	import bta_pkg::*;

	localparam int AW   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CW   = $clog2(NUM_BLOCKS + 1);
	localparam int MW   = (CW > BIU_W) ? CW : BIU_W;
	localparam int RB_W = SIZE_W + 1;
	localparam int AC_W = ADDR_W + 2;
	localparam int PR_W = AW + 17;

	localparam logic [RB_W-1:0] BS_RB  = RB_W'(BLOCK_SIZE);
	localparam logic [AC_W-1:0] BS_AC  = AC_W'(BLOCK_SIZE);
	localparam logic [16:0]     BS_PR  = 17'(BLOCK_SIZE);
	localparam logic [CW-1:0]   NB_CNT = CW'(NUM_BLOCKS);
	localparam logic [CW-1:0]   NB_LST = CW'(NUM_BLOCKS - 1);

	state_t state_q, state_d;

	// Configuration registers
	logic [ADDR_W-1:0] base_q;
	logic [BIU_W-1:0]  blocks_q;

	// Request registers
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] offset_q;

	// Sweep and stream state
	logic [CW-1:0]     issue_q;
	logic              valid_s1;
	logic [AW-1:0]     idx_s1;
	logic [RB_W-1:0]   run_q;
	logic [AW-1:0]     start_q;
	logic [AW-1:0]     end_q;
	logic [AW-1:0]     mark_q;
	logic [ADDR_W-1:0] prod_q;
	logic [CW-1:0]     widx_q;
	logic [AC_W-1:0]   acc_q;

	// Pending result and output register
	status_t           st_q;
	logic [ADDR_W-1:0] ra_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [ADDR_W-1:0] out_addr_q;

	// Memory port
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	entry_t            ram_wdata;
	logic              ram_re;
	entry_t            ram_rdata;

	// Derived control
	logic [CW-1:0]     n_used;
	logic              in_fire;
	logic              issue_ok;
	logic              ent_taken;
	logic              ent_next;
	logic [RB_W-1:0]   run_next;
	logic              run_hit;
	logic              scan_hit;
	logic              scan_miss;
	logic              chain_end;
	logic              walk_bad;
	logic              walk_hit;
	logic              mark_last;
	logic              resp_load;
	logic              req_bad;
	logic [PR_W-1:0]   prod_full;

	// Clamp the entry count to the table depth
	always_comb begin
		if (MW'(blocks_q) > MW'(NUM_BLOCKS)) begin
			n_used = NB_CNT;
		end else begin
			n_used = CW'(blocks_q);
		end
	end

	assign in_fire   = in_valid && !in_stall;
	assign issue_ok  = (issue_q < n_used);
	assign ent_taken = ram_rdata[ENT_TAKEN];
	assign ent_next  = ram_rdata[ENT_NEXT];
	assign run_next  = run_q + BS_RB;
	assign run_hit   = (run_next >= RB_W'(size_q));
	assign scan_hit  = valid_s1 && !ent_taken && run_hit;
	assign scan_miss = !valid_s1 && !issue_ok;
	assign chain_end = (valid_s1 && !ent_next) || (!valid_s1 && !issue_ok);
	assign walk_bad  = (widx_q >= n_used);
	assign walk_hit  = (AC_W'(offset_q) < (acc_q + BS_AC));
	assign mark_last = (mark_q == end_q);
	assign resp_load = !out_valid_q || !out_stall;
	assign prod_full = PR_W'(idx_s1) * PR_W'(BS_PR);
	assign req_bad   = (func == FUNC_ALLOC) ? (size_bytes == '0) : (address < base_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (issue_q == NB_LST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_fire) begin
					if (req_bad) begin
						state_d = S_RESP;
					end else if (func == FUNC_ALLOC) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_FWALK;
					end
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					state_d = S_MARK;
				end else if (scan_miss) begin
					state_d = S_RESP;
				end
			end
			S_MARK: begin
				if (mark_last) begin
					state_d = S_RESP;
				end
			end
			S_FWALK: begin
				if (walk_bad) begin
					state_d = S_RESP;
				end else if (walk_hit) begin
					state_d = S_FCHAIN;
				end
			end
			S_FCHAIN: begin
				if (chain_end) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (resp_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Memory port and handshake outputs
	always_comb begin
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = issue_q[AW-1:0];
		ram_wdata = ENTRY_FREE;
		ram_re    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_IDLE: begin
				in_stall = 1'b0;
			end
			S_SCAN: begin
				ram_re = issue_ok;
			end
			S_MARK: begin
				ram_we                = 1'b1;
				ram_waddr             = mark_q;
				ram_wdata[ENT_TAKEN]  = 1'b1;
				ram_wdata[ENT_FIRST]  = (mark_q == start_q);
				ram_wdata[ENT_NEXT]   = !mark_last;
			end
			S_FCHAIN: begin
				ram_re    = issue_ok;
				ram_we    = valid_s1;
				ram_waddr = idx_s1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			blocks_q <= BIU_W'(1024);
		end else if (cfg_we) begin
			if (cfg_index == CFG_BASE) begin
				base_q <= cfg_wdata;
			end else begin
				blocks_q <= cfg_wdata[BIU_W-1:0];
			end
		end
	end

	// Sweep counter and read stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ram_re;
			case (state_q)
				S_CLEAR: begin
					issue_q <= issue_q + 1'b1;
				end
				S_IDLE: begin
					issue_q <= '0;
				end
				S_SCAN, S_FCHAIN: begin
					if (ram_re) begin
						issue_q <= issue_q + 1'b1;
					end
				end
				S_FWALK: begin
					issue_q <= widx_q;
				end
				default: begin
					issue_q <= issue_q;
				end
			endcase
		end
	end

	// Track the request, stream index, free run, marking pointer and free walk
	always_ff @(posedge clk) begin
		idx_s1 <= issue_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				size_q   <= size_bytes;
				offset_q <= address - base_q;
				run_q    <= '0;
				widx_q   <= '0;
				acc_q    <= '0;
			end
			S_SCAN: begin
				if (valid_s1) begin
					if (ent_taken) begin
						run_q <= '0;
					end else begin
						run_q <= run_next;
						if (run_q == '0) begin
							start_q <= idx_s1;
							prod_q  <= ADDR_W'(prod_full);
						end
					end
				end
				end_q  <= idx_s1;
				mark_q <= (run_q == '0) ? idx_s1 : start_q;
			end
			S_MARK: begin
				mark_q <= mark_q + 1'b1;
			end
			S_FWALK: begin
				widx_q <= widx_q + 1'b1;
				acc_q  <= acc_q + BS_AC;
			end
			default: begin
				run_q <= run_q;
			end
		endcase
	end

	// Build the pending result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				st_q <= req_bad ? ST_BAD : ST_OK;
				ra_q <= '0;
			end
			S_SCAN: begin
				if (scan_miss) begin
					st_q <= ST_OOM;
				end
			end
			S_MARK: begin
				ra_q <= base_q + prod_q;
			end
			S_FWALK: begin
				if (walk_bad) begin
					st_q <= ST_BAD;
				end
			end
			default: begin
				st_q <= st_q;
			end
		endcase
	end

	// Output register: load a finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESP && resp_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && resp_load) begin
			out_status_q <= st_q;
			out_addr_q   <= ra_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign result_address = out_addr_q;

	bta_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (issue_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// A new result word appears only out of the response state
	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP))
		else $error("result word loaded outside response state");

	// The scan only reads the table
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !ram_we)
		else $error("table written during scan");

	// Marking stays inside the found run
	a_mark_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK) |-> (mark_q >= start_q && mark_q <= end_q))
		else $error("mark pointer outside the run");

	// Reads never pass the entries in use
	a_read_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (issue_q < n_used))
		else $error("table read beyond entries in use");

	// A free never writes past the entry where its chain ended
	a_chain_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FCHAIN && valid_s1 && !ent_next) |=> (state_q == S_RESP))
		else $error("free chain ran past an entry without next mark");

endmodule

/* tb/block_table_heap_allocator_tb.sv */
// ----------------------------------------------------------------------------
// block_table_heap_allocator_tb
// Self-checking bench for the first-fit block table allocator. A shadow copy
// of the block table follows every accepted request and gives the reply that
// the block must return; replies are compared in order, field by field.
// Directed requests cover the edge cases, then random alloc/free traffic runs
// under several heap settings, most with random gaps on both channels.
// ----------------------------------------------------------------------------
module block_table_heap_allocator_tb;

	import bta_pkg::*;

	localparam int NUM_BLOCKS = 1024;
	localparam int BLOCK_SIZE = 4096;
	localparam int MAX_SIZE   = 4194304;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int HOLD_CYCLES = 600;
	localparam logic [ADDR_W-1:0] DIR_BASE = 32'h8000_0000;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		status_t           status;
	} reply_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [31:0]         cfg_wdata;
	logic                in_valid;
	logic                in_stall;
	logic                func;
	logic [SIZE_W-1:0]   size_bytes;
	logic [ADDR_W-1:0]   address;
	logic                out_valid;
	logic                out_stall;
	logic [ADDR_W-1:0]   result_address;
	logic [STATUS_W-1:0] status;

	// Shadow heap state
	entry_t             shadow_tbl [NUM_BLOCKS];
	logic [ADDR_W-1:0]  shadow_base;
	logic [BIU_W-1:0]   shadow_biu;

	reply_t      reply_q [$];
	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned stall_left = 0;
	bit          idle_on = 1'b1;
	bit          hold_req = 1'b0;
	logic        rx_hold;

	block_table_heap_allocator #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.BLOCK_SIZE (BLOCK_SIZE)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.size_bytes     (size_bytes),
		.address        (address),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_address (result_address),
		.status         (status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Compute the reply to one request and advance the shadow table
	function automatic reply_t heap_reply(input logic f, input logic [SIZE_W-1:0] sz,
			input logic [ADDR_W-1:0] ad);
		reply_t            r;
		int unsigned       n;
		int unsigned       need;
		int unsigned       run;
		int unsigned       start;
		int unsigned       idx;
		bit                found;
		entry_t            e;
		logic [ADDR_W-1:0] ofs;
		r.addr   = '0;
		r.status = ST_OK;
		n     = (shadow_biu > NUM_BLOCKS) ? NUM_BLOCKS : shadow_biu;
		run   = 0;
		start = 0;
		found = 1'b0;
		if (f == FUNC_ALLOC) begin
			need = (32'(sz) + BLOCK_SIZE - 1) / BLOCK_SIZE;
			if (sz == '0) begin
				r.status = ST_BAD;
			end else if (need > n) begin
				r.status = ST_OOM;
			end else begin
				// first fit over the entries in use
				for (int unsigned i = 0; i < n; i++) begin
					if (shadow_tbl[i][ENT_TAKEN]) begin
						run = 0;
					end else begin
						if (run == 0)
							start = i;
						run++;
						if (run == need) begin
							found = 1'b1;
							break;
						end
					end
				end
				if (!found) begin
					r.status = ST_OOM;
				end else begin
					for (int unsigned i = 0; i < need; i++) begin
						e = ENTRY_FREE;
						e[ENT_TAKEN] = 1'b1;
						if (i == 0)
							e[ENT_FIRST] = 1'b1;
						if (i + 1 < need)
							e[ENT_NEXT] = 1'b1;
						shadow_tbl[start + i] = e;
					end
					r.addr = shadow_base + start * BLOCK_SIZE;
				end
			end
		end else begin
			if (ad < shadow_base) begin
				r.status = ST_BAD;
			end else begin
				ofs = ad - shadow_base;
				idx = ofs / BLOCK_SIZE;
				if (idx >= n) begin
					r.status = ST_BAD;
				end else begin
					// walk the chain until an entry without a successor
					for (int unsigned i = idx; i < n; i++) begin
						e = shadow_tbl[i];
						shadow_tbl[i] = ENTRY_FREE;
						if (!e[ENT_NEXT])
							break;
					end
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_cnt, what);
		mismatch_cnt++;
	endtask

	// Register write, only while the block is idle: the caller must see to it, the task does not check
	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == CFG_BASE)
			shadow_base = val;
		else
			shadow_biu = val[BIU_W-1:0];
	endtask

	// Offer one request word and record its reply once it is taken
	task automatic send_req(input logic f, input logic [SIZE_W-1:0] sz,
			input logic [ADDR_W-1:0] ad, output reply_t r);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		size_bytes <= sz;
		address    <= ad;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = heap_reply(f, sz, ad);
		reply_q.push_back(r);
	endtask

	// Drop valid and wait for every pending reply
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Receive side: check each result word, then draw the next stall
	always @(posedge clk) begin
		reply_t want;
		bit     taken;
		taken = out_valid && !out_stall;
		if (taken) begin
			if (reply_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h/%0d", result_address,
					status));
			end else begin
				want = reply_q.pop_front();
				if (result_address !== want.addr)
					report_mismatch($sformatf("result_address %h, want %h",
						result_address, want.addr));
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", status,
						want.status));
			end
			stall_left = idle_on ? $urandom_range(0, 11) : 0;
		end
		if (rx_hold) begin
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			if (out_valid && !taken)
				stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Long receiver hold-off, so the block fills up and stalls its input
	initial begin
		rx_hold = 1'b0;
		while (!hold_req)
			@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Edge cases on a 16-entry heap
	task automatic test_directed();
		reply_t r;
		write_reg(CFG_BASE, DIR_BASE);
		write_reg(CFG_BLOCKS, 32'd16);
		send_req(FUNC_ALLOC, '0, '0, r);
		send_req(FUNC_ALLOC, 23'd1, '0, r);
		send_req(FUNC_ALLOC, SIZE_W'(BLOCK_SIZE), '0, r);
		send_req(FUNC_ALLOC, SIZE_W'(BLOCK_SIZE + 1), '0, r);
		send_req(FUNC_ALLOC, SIZE_W'(17 * BLOCK_SIZE), '0, r);
		send_req(FUNC_ALLOC, SIZE_W'(MAX_SIZE), '1, r);
		// free the tail of a run, then its head at an unaligned address
		send_req(FUNC_FREE, '0, DIR_BASE + 3 * BLOCK_SIZE, r);
		send_req(FUNC_FREE, '0, DIR_BASE + 2 * BLOCK_SIZE + 123, r);
		send_req(FUNC_FREE, '0, DIR_BASE + 10 * BLOCK_SIZE, r);
		send_req(FUNC_FREE, '0, DIR_BASE - 1, r);
		send_req(FUNC_FREE, '0, DIR_BASE + 16 * BLOCK_SIZE, r);
		send_req(FUNC_FREE, '0, '1, r);
		// leave two free entries at the end, then ask for three
		send_req(FUNC_ALLOC, SIZE_W'(12 * BLOCK_SIZE), '0, r);
		send_req(FUNC_ALLOC, SIZE_W'(3 * BLOCK_SIZE), '0, r);
		send_req(FUNC_ALLOC, SIZE_W'(2 * BLOCK_SIZE), '0, r);
		send_req(FUNC_FREE, '0, DIR_BASE + 2 * BLOCK_SIZE, r);
		send_req(FUNC_FREE, '0, DIR_BASE, r);
		send_req(FUNC_FREE, '0, DIR_BASE + BLOCK_SIZE, r);
		send_req(FUNC_FREE, '0, DIR_BASE + 14 * BLOCK_SIZE, r);
		wait_idle();
	endtask

	// Entries in use at zero, one and beyond the table depth
	task automatic test_blocks_extremes();
		reply_t r;
		write_reg(CFG_BLOCKS, 32'd0);
		send_req(FUNC_ALLOC, SIZE_W'(BLOCK_SIZE), '0, r);
		send_req(FUNC_FREE, '0, DIR_BASE, r);
		wait_idle();

		write_reg(CFG_BASE, 32'hFFFF_FFFF);
		write_reg(CFG_BLOCKS, 32'd1);
		send_req(FUNC_ALLOC, 23'd1, '0, r);
		send_req(FUNC_ALLOC, 23'd1, '0, r);
		send_req(FUNC_FREE, '0, 32'hFFFF_FFFF, r);
		send_req(FUNC_FREE, '0, '0, r);
		wait_idle();

		// count above the table depth is capped; take the whole table at once
		write_reg(CFG_BASE, 32'd0);
		write_reg(CFG_BLOCKS, 32'd2047);
		send_req(FUNC_ALLOC, SIZE_W'(MAX_SIZE), '0, r);
		send_req(FUNC_ALLOC, 23'd1, '0, r);
		send_req(FUNC_FREE, '0, 32'((NUM_BLOCKS - 1) * BLOCK_SIZE + 5), r);
		send_req(FUNC_FREE, '0, '0, r);
		send_req(FUNC_FREE, '0, 32'(NUM_BLOCKS * BLOCK_SIZE), r);
		wait_idle();
	endtask

	// Random alloc/free traffic: allocations, frees of live regions, some noise
	task automatic test_random_heap(input int n_items, input int max_blocks,
			input logic [ADDR_W-1:0] base, input logic [BIU_W-1:0] blocks,
			input bit idle, input bit squeeze);
		logic [ADDR_W-1:0] live_q [$];
		logic [ADDR_W-1:0] a;
		reply_t            r;
		int unsigned       pick;
		int unsigned       k;
		int unsigned       span;
		write_reg(CFG_BASE, base);
		write_reg(CFG_BLOCKS, 32'(blocks));
		idle_on = idle;
		span = (blocks > NUM_BLOCKS) ? NUM_BLOCKS : blocks;
		for (int i = 0; i < n_items; i++) begin
			if (squeeze && i == n_items / 3)
				hold_req = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 50 || live_q.size() == 0) begin
				send_req(FUNC_ALLOC, SIZE_W'($urandom_range(1, max_blocks * BLOCK_SIZE)),
					$urandom(), r);
				if (r.status == ST_OK)
					live_q.push_back(r.addr);
			end else if (pick < 88) begin
				k = $urandom_range(0, live_q.size() - 1);
				a = live_q[k];
				live_q.delete(k);
				if ($urandom_range(0, 3) == 0)
					a = a + $urandom_range(1, BLOCK_SIZE - 1);
				send_req(FUNC_FREE, SIZE_W'($urandom_range(0, MAX_SIZE)), a, r);
			end else begin
				case ($urandom_range(0, 3))
					0: begin
						send_req(FUNC_ALLOC, SIZE_W'($urandom_range(0, MAX_SIZE)),
							$urandom(), r);
						if (r.status == ST_OK)
							live_q.push_back(r.addr);
					end
					1: send_req(FUNC_FREE, SIZE_W'($urandom_range(0, MAX_SIZE)),
						$urandom(), r);
					2: send_req(FUNC_FREE, SIZE_W'($urandom_range(0, MAX_SIZE)),
						base + $urandom_range(0, span * BLOCK_SIZE - 1), r);
					default: send_req(FUNC_ALLOC, '0, $urandom(), r);
				endcase
			end
		end
		// release what is still held before the next setting
		while (live_q.size() != 0) begin
			a = live_q.pop_front();
			send_req(FUNC_FREE, '0, a, r);
		end
		wait_idle();
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_BASE;
		cfg_wdata  = '0;
		in_valid   = 1'b0;
		func       = FUNC_ALLOC;
		size_bytes = '0;
		address    = '0;
		shadow_base = '0;
		shadow_biu  = BIU_W'(NUM_BLOCKS);
		foreach (shadow_tbl[i])
			shadow_tbl[i] = ENTRY_FREE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_blocks_extremes();
		test_random_heap(90, 6, 32'h3A5C_0000 | (32'($urandom()) & 32'h0FFF_F000),
			11'd64, 1'b1, 1'b1);
		test_random_heap(55, 4, 32'hFFFF_8000, 11'd24, 1'b0, 1'b0);
		test_random_heap(45, 10, $urandom(), BIU_W'($urandom_range(8, 200)), 1'b1, 1'b0);
		test_random_heap(30, 64, 32'd0, 11'd1024, 1'b1, 1'b0);

		// let any stray result word show up
		repeat (2200) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("[block_table_heap_allocator] OK");
		else
			$display("[block_table_heap_allocator] ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("[block_table_heap_allocator] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
rtl/bta_pkg.sv
rtl/bta_ram.sv
rtl/block_table_heap_allocator.sv
tb/block_table_heap_allocator_tb.sv
